FILE: hw/rtl/spectrometer_pixel_irradiance_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pixel irradiance block
// Synthesis builds define SYNTH and get empty bodies.
// ---------------------------------------------------------------------------
`ifndef SPECTROMETER_PIXEL_IRRADIANCE_MACROS_SVH
`define SPECTROMETER_PIXEL_IRRADIANCE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spi assertion failed");
// next-cycle implication
`define SPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spi assertion failed");
`else
`define SPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/spi_pkg.sv
// ---------------------------------------------------------------------------
// spi_pkg
// Word types, register indexes and fixed constants of the irradiance block.
// ---------------------------------------------------------------------------
package spi_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_W = 32;
    localparam int ACC_W = 36;
    localparam int XN_W = 16;
    localparam int TF_W = 24;
    localparam int CAL_W = 32;
    localparam int LIN_SHIFT = 44;
    localparam int OUT_W = 32;
    localparam int NUM_COEF = 8;

    localparam logic signed [ACC_W-1:0] ONE_Q28 = 36'sd268435456;
    localparam logic [OUT_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIN_EN   = 3'd0,
        REG_LOW      = 3'd1,
        REG_HIGH     = 3'd2,
        REG_TIME     = 3'd3,
        REG_COEF_A   = 3'd4,
        REG_COEF_B   = 3'd5,
        REG_COEF_C   = 3'd6,
        REG_COEF_D   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] raw_count;
        logic [15:0] dark_count;
        logic [31:0] calib_factor;
        logic        last_pixel;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] irradiance;
        logic               saturated;
        logic               calib_zero;
        logic               last_out;
    } t_out_word;

endpackage

FILE: hw/rtl/spectrometer_pixel_irradiance.sv
// ---------------------------------------------------------------------------
// spectrometer_pixel_irradiance
// Dark subtraction, polynomial nonlinearity correction, calibration divide
// and time scaling of one pixel per cycle, saturated to signed Q16.16.
// ---------------------------------------------------------------------------
// Pipeline: stage A, the Horner multiply and shift-add stages, stage P, divider 1,
//   stages M, S and C, divider 2 and stage F; the dividers give one quotient bit a stage.
// Throughput: one word per cycle while the output side takes words; the
//   whole pipe holds when the output word is not taken.
// Reset: synchronous, active low; clears all stage valid bits and loads the
//   register defaults. No clearing pass.
module spectrometer_pixel_irradiance
    import spi_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int POLY_DEGREE = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "spectrometer_pixel_irradiance_macros.svh"

    localparam int CB = COUNT_BITS;
    localparam int PD = POLY_DEGREE;
    localparam int DW = CB + 1;                // signed dark-corrected count
    localparam int QW = CB + LIN_SHIFT;        // numerator and linearized width
    localparam int DIV_W = ACC_W;              // |P| width
    localparam int LH = (QW + 1) / 2;          // low half of lin for the multiply
    localparam int LHI = QW - LH;
    localparam int PRW = QW + TF_W;            // lin * time factor
    localparam int SH_L = (CB < XN_W) ? (XN_W - CB) : 0;
    localparam int SH_R = (CB >= XN_W) ? (CB - XN_W) : 0;

    // Item sideband that rides along the whole pipe.
    typedef struct packed {
        logic [CB-1:0]    mag;
        logic             neg;
        logic [XN_W-1:0]  xn;
        logic [CAL_W-1:0] cal;
        logic             last;
        logic             over;
    } t_side;

    // ---------------- configuration registers ----------------
    logic                  r_lin_en;
    logic [15:0]           r_low;
    logic [15:0]           r_high;
    logic [TF_W-1:0]       r_tf;
    logic [CFG_DATA_W-1:0] r_pair [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_en <= 1'b0;
            r_low    <= 16'd0;
            r_high   <= 16'hFFFF;
            r_tf     <= 24'd65536;
            r_pair[0] <= 64'd268435456;
            r_pair[1] <= '0;
            r_pair[2] <= '0;
            r_pair[3] <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LIN_EN: r_lin_en  <= i_cfg_data[0];
                REG_LOW:    r_low     <= i_cfg_data[15:0];
                REG_HIGH:   r_high    <= i_cfg_data[15:0];
                REG_TIME:   r_tf      <= i_cfg_data[TF_W-1:0];
                REG_COEF_A: r_pair[0] <= i_cfg_data;
                REG_COEF_B: r_pair[1] <= i_cfg_data;
                REG_COEF_C: r_pair[2] <= i_cfg_data;
                REG_COEF_D: r_pair[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack coefficients: even index in the low half, sign-extended to ACC_W.
    logic signed [ACC_W-1:0] w_coef [NUM_COEF];
    for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
        assign w_coef[k] = ACC_W'($signed(r_pair[k/2][(k%2)*COEF_W +: COEF_W]));
    end

    // ---------------- global advance ----------------
    // Every stage moves together; hold everything while the output word waits.
    logic r_out_vld;
    logic w_adv;
    assign w_adv = !r_out_vld || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- stage A: dark subtract and clamp ----------------
    logic [CB-1:0]        w_raw;
    logic [CB-1:0]        w_dark;
    logic [CB-1:0]        w_lo;
    logic [CB-1:0]        w_hi;
    logic signed [DW-1:0] w_d;
    logic [CB-1:0]        w_x;
    t_side                n_a_side;
    logic                 r_a_vld;
    t_side                r_a_side;

    always_comb begin
        w_raw  = CB'(i_in_word.raw_count);
        w_dark = CB'(i_in_word.dark_count);
        w_lo   = CB'(r_low);
        w_hi   = CB'(r_high);
        w_d    = $signed({1'b0, w_raw}) - $signed({1'b0, w_dark});
        // low test first, so with low above high a value below low picks low, any other picks high
        if (w_d < $signed({1'b0, w_lo})) begin
            w_x = w_lo;
        end else if (w_d > $signed({1'b0, w_hi})) begin
            w_x = w_hi;
        end else begin
            w_x = w_d[CB-1:0];
        end
        n_a_side.neg  = w_d[DW-1];
        n_a_side.mag  = w_d[DW-1] ? CB'(-w_d) : w_d[CB-1:0];
        // normalize the evaluation point to Q0.16
        n_a_side.xn   = XN_W'(((XN_W + CB)'(w_x) << SH_L) >> SH_R);
        n_a_side.cal  = i_in_word.calib_factor;
        n_a_side.last = i_in_word.last_pixel;
        n_a_side.over = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_side <= n_a_side;
        end
    end

    // ---------------- Horner: multiply stage then shift-add stage ----------
    logic                          r_hm_vld  [PD];
    t_side                         r_hm_side [PD];
    logic signed [ACC_W+XN_W:0]    r_hm_prod [PD];
    logic                          r_ha_vld  [PD];
    t_side                         r_ha_side [PD];
    logic signed [ACC_W-1:0]       r_ha_acc  [PD];

    for (genvar j = 0; j < PD; j++) begin : g_horner
        logic                       vld_in;
        t_side                      side_in;
        logic signed [ACC_W-1:0]    acc_in;
        logic signed [ACC_W+XN_W:0] n_prod;
        logic signed [ACC_W-1:0]    n_acc;

        if (j == 0) begin : g_src
            assign vld_in  = r_a_vld;
            assign side_in = r_a_side;
            assign acc_in  = w_coef[PD];
        end else begin : g_src
            assign vld_in  = r_ha_vld[j-1];
            assign side_in = r_ha_side[j-1];
            assign acc_in  = r_ha_acc[j-1];
        end

        assign n_prod = acc_in * $signed({1'b0, side_in.xn});
        // floor of prod / 2^16, then add the next coefficient
        assign n_acc  = ACC_W'(r_hm_prod[j] >>> XN_W) + w_coef[PD-1-j];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hm_vld[j] <= 1'b0;
                r_ha_vld[j] <= 1'b0;
            end else if (w_adv) begin
                r_hm_vld[j] <= vld_in;
                r_ha_vld[j] <= r_hm_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_hm_side[j] <= side_in;
                r_hm_prod[j] <= n_prod;
                r_ha_side[j] <= r_hm_side[j];
                r_ha_acc[j]  <= n_acc;
            end
        end
    end

    // ---------------- stage P: divisor setup ----------------
    // Bypass uses a divisor of 1.0, which gives mag << 16 exactly.
    logic signed [ACC_W-1:0] n_p_poly;
    logic                    w_p_neg;
    t_side                   n_p_side;
    logic                    r_p_vld;
    t_side                   r_p_side;
    logic [DIV_W-1:0]        r_p_div;
    logic [QW-1:0]           r_p_nq;

    always_comb begin
        if (!r_lin_en || (r_ha_acc[PD-1] == '0)) begin
            n_p_poly = ONE_Q28;
        end else begin
            n_p_poly = r_ha_acc[PD-1];
        end
        w_p_neg      = n_p_poly[ACC_W-1];
        n_p_side     = r_ha_side[PD-1];
        n_p_side.neg = r_ha_side[PD-1].neg ^ w_p_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= r_ha_vld[PD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_side <= n_p_side;
            r_p_div  <= w_p_neg ? DIV_W'(-n_p_poly) : DIV_W'(n_p_poly);
            r_p_nq   <= {r_ha_side[PD-1].mag, {LIN_SHIFT{1'b0}}};
        end
    end

    // ---------------- divider 1: (mag << 44) / |P|, one bit a stage ---------
    // Numerator bits shift out of the top of nq as quotient bits shift in.
    logic             r_d1_vld  [QW];
    t_side            r_d1_side [QW];
    logic [DIV_W-1:0] r_d1_rem  [QW];
    logic [DIV_W-1:0] r_d1_div  [QW];
    logic [QW-1:0]    r_d1_nq   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div1
        logic             vld_in;
        t_side            side_in;
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] div_in;
        logic [QW-1:0]    nq_in;
        logic [DIV_W:0]   trial;
        logic             ge;

        if (i == 0) begin : g_src
            assign vld_in  = r_p_vld;
            assign side_in = r_p_side;
            assign rem_in  = '0;
            assign div_in  = r_p_div;
            assign nq_in   = r_p_nq;
        end else begin : g_src
            assign vld_in  = r_d1_vld[i-1];
            assign side_in = r_d1_side[i-1];
            assign rem_in  = r_d1_rem[i-1];
            assign div_in  = r_d1_div[i-1];
            assign nq_in   = r_d1_nq[i-1];
        end

        assign trial = {rem_in, nq_in[QW-1]};
        assign ge    = trial >= {1'b0, div_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_vld[i] <= 1'b0;
            end else if (w_adv) begin
                r_d1_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d1_side[i] <= side_in;
                r_d1_div[i]  <= div_in;
                r_d1_rem[i]  <= ge ? DIV_W'(trial - {1'b0, div_in}) : DIV_W'(trial);
                r_d1_nq[i]   <= {nq_in[QW-2:0], ge};
            end
        end
    end

    // ---------------- stage M: partial products lin * time factor ----------
    logic [QW-1:0]        w_lin;
    t_side                n_m_side;
    logic                 r_m_vld;
    t_side                r_m_side;
    logic [LH+TF_W-1:0]   r_m_lo;
    logic [LHI+TF_W-1:0]  r_m_hi;
    logic [LH+TF_W-1:0]   n_m_lo;
    logic [LHI+TF_W-1:0]  n_m_hi;

    assign w_lin = r_d1_nq[QW-1];
    assign n_m_lo = w_lin[LH-1:0] * r_tf;
    assign n_m_hi = w_lin[QW-1:LH] * r_tf;

    always_comb begin
        n_m_side     = r_d1_side[QW-1];
        // a zero result is never negative
        n_m_side.neg = r_d1_side[QW-1].neg && (w_lin != '0);
    end

    // ---------------- stage S: sum partial products ----------------
    logic             r_s_vld;
    t_side            r_s_side;
    logic [PRW-1:0]   r_s_prod;

    // ---------------- stage C: range check against 2^32 * cal -----------
    t_side            n_c_side;
    logic             r_c_vld;
    t_side            r_c_side;
    logic [CAL_W-1:0] r_c_rem;
    logic [CAL_W-1:0] r_c_nq;

    always_comb begin
        n_c_side      = r_s_side;
        n_c_side.over = r_s_prod[PRW-1:CAL_W] >= (PRW - CAL_W)'(r_s_side.cal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld <= r_d1_vld[QW-1];
            r_s_vld <= r_m_vld;
            r_c_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_side <= n_m_side;
            r_m_lo   <= n_m_lo;
            r_m_hi   <= n_m_hi;
            r_s_side <= r_m_side;
            r_s_prod <= (PRW'(r_m_hi) << LH) + PRW'(r_m_lo);
            r_c_side <= n_c_side;
            r_c_rem  <= r_s_prod[2*CAL_W-1:CAL_W];
            r_c_nq   <= r_s_prod[CAL_W-1:0];
        end
    end

    // ---------------- divider 2: 32-bit quotient by cal ----------------
    // Only meaningful when the check stage found no overflow.
    logic             r_d2_vld  [CAL_W];
    t_side            r_d2_side [CAL_W];
    logic [CAL_W-1:0] r_d2_rem  [CAL_W];
    logic [CAL_W-1:0] r_d2_nq   [CAL_W];

    for (genvar i = 0; i < CAL_W; i++) begin : g_div2
        logic             vld_in;
        t_side            side_in;
        logic [CAL_W-1:0] rem_in;
        logic [CAL_W-1:0] nq_in;
        logic [CAL_W:0]   trial;
        logic             ge;

        if (i == 0) begin : g_src
            assign vld_in  = r_c_vld;
            assign side_in = r_c_side;
            assign rem_in  = r_c_rem;
            assign nq_in   = r_c_nq;
        end else begin : g_src
            assign vld_in  = r_d2_vld[i-1];
            assign side_in = r_d2_side[i-1];
            assign rem_in  = r_d2_rem[i-1];
            assign nq_in   = r_d2_nq[i-1];
        end

        assign trial = {rem_in, nq_in[CAL_W-1]};
        assign ge    = trial >= {1'b0, side_in.cal};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_vld[i] <= 1'b0;
            end else if (w_adv) begin
                r_d2_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d2_side[i] <= side_in;
                r_d2_rem[i]  <= ge ? CAL_W'(trial - {1'b0, side_in.cal}) : CAL_W'(trial);
                r_d2_nq[i]   <= {nq_in[CAL_W-2:0], ge};
            end
        end
    end

    // ---------------- stage F: saturate, sign and output register ----------
    t_side            w_f_side;
    logic [OUT_W-1:0] w_f_q;
    logic [OUT_W-1:0] w_f_limit;
    logic [OUT_W-1:0] w_f_mag;
    logic             w_f_sat;
    t_out_word        n_out;
    t_out_word        r_out;

    always_comb begin
        w_f_side  = r_d2_side[CAL_W-1];
        w_f_q     = r_d2_nq[CAL_W-1];
        w_f_limit = w_f_side.neg ? NEG_LIMIT : POS_LIMIT;
        // zero cal always trips the overflow check as well
        w_f_sat   = w_f_side.over || (w_f_q > w_f_limit);
        w_f_mag   = w_f_sat ? w_f_limit : w_f_q;
        n_out.irradiance = w_f_side.neg ? $signed(-w_f_mag) : $signed(w_f_mag);
        n_out.saturated  = w_f_sat;
        n_out.calib_zero = (w_f_side.cal == '0);
        n_out.last_out   = w_f_side.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_d2_vld[CAL_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // ---------------- assertions ----------------
    `SPI_ASSERT_IMP(a_czero_sat, i_clk, i_rst_n, r_out_vld && r_out.calib_zero, r_out.saturated)
    `SPI_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, r_out_vld && r_out.saturated, (r_out.irradiance == POS_LIMIT) || (r_out.irradiance == NEG_LIMIT))
    `SPI_ASSERT_IMP(a_cal_over, i_clk, i_rst_n, r_c_vld && (r_c_side.cal == '0), r_c_side.over)
    `SPI_ASSERT_NXT(a_hold, i_clk, i_rst_n, !w_adv, $stable(r_d2_vld[CAL_W-1]) && $stable(r_p_vld))

endmodule
